@@ src/bst_pkg.sv @@
// Package for the byte stream tokenizer: widths, token kinds, scanner modes,
// the queue depth and the character-class helpers.
// No dependencies; every other file imports it.
`timescale 1ns / 1ps
`default_nettype none

package bst_pkg;

  localparam int POSITION_BITS = 16;
  localparam int BYTE_W        = 8;
  localparam int START_W       = 16;
  localparam int LEN_W         = 16;
  localparam int KIND_W        = 3;

  localparam logic [LEN_W-1:0] LEN_MAX     = {LEN_W{1'b1}};
  localparam logic [LEN_W-1:0] KEYWORD_LEN = LEN_W'(5);

  // Result queue: room for a burst of two-result requests
  localparam int QUEUE_DEPTH = 4;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [KIND_W-1:0] {
    KIND_INTEGER = 3'd0,
    KIND_PRINT   = 3'd1,
    KIND_IDENT   = 3'd2,
    KIND_ILLEGAL = 3'd3,
    KIND_END     = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_INTEGER = 2'd1,
    MODE_IDENT   = 2'd2
  } mode_t;

  typedef struct packed {
    kind_t               kind;
    logic [START_W-1:0]  start;
    logic [LEN_W-1:0]    length;
    logic [BYTE_W-1:0]   bad;
    logic                last;
  } token_t;

  function automatic logic is_ws(input logic [BYTE_W-1:0] b);
    return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
  endfunction

  function automatic logic is_digit(input logic [BYTE_W-1:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_word_start(input logic [BYTE_W-1:0] b);
    return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A)) ||
           (b == 8'h5F);
  endfunction

  // Letters of the keyword "print", by position
  function automatic logic [BYTE_W-1:0] print_char(input logic [2:0] idx);
    logic [BYTE_W-1:0] c;
    case (idx)
      3'd0:    c = 8'h70;
      3'd1:    c = 8'h72;
      3'd2:    c = 8'h69;
      3'd3:    c = 8'h6E;
      3'd4:    c = 8'h74;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

@@ src/bst_ifs.sv @@
// Valid/ready channel interfaces of the byte stream tokenizer: text bytes in,
// tokens out. Depends on bst_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface bst_in_if;
  import bst_pkg::*;

  logic                valid;
  logic                ready;
  logic [BYTE_W-1:0]   text_byte;
  logic                end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface bst_out_if;
  import bst_pkg::*;

  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   token_kind;
  logic [START_W-1:0]  token_start;
  logic [LEN_W-1:0]    token_length;
  logic [BYTE_W-1:0]   illegal_byte;
  logic                last_of_run;

  modport source (output valid, output token_kind, output token_start,
                  output token_length, output illegal_byte, output last_of_run,
                  input ready);
  modport sink   (input valid, input token_kind, input token_start,
                  input token_length, input illegal_byte, input last_of_run,
                  output ready);
endinterface

`default_nettype wire

@@ src/byte_stream_tokenizer.sv @@
// Byte stream tokenizer: one text byte per request in, tokens out as
// kind / start / length. Depends on bst_pkg and the channels in bst_ifs.sv.
//
// Usage:
//   in_stream  (sink)   one request per text byte; end_of_text=1 closes the text
//                       (text_byte is then ignored).
//   out_stream (source) one request per token; last_of_run marks the final
//                       token caused by an input request.
//   A byte is classified and the scanner state updated in the cycle it is
//   accepted; the token(s) it completes land in a 4-entry result queue, whose
//   registered head drives out_stream. The queue drains one token per cycle
//   while out_stream.ready is high. Throughput: one byte per cycle whenever
//   each byte causes at most one token and out_stream is not stalled. A byte
//   that ends a pending token and is itself illegal, or an end of text with a
//   token pending, pushes two tokens; such bursts fill the queue, and
//   in_stream.ready drops while fewer than two slots are free.
//   Reset: scanner idle, byte position zero, queue empty. End of text returns
//   the scanner to the same state, so the next byte starts a new text.
//   Receiver stall: queued tokens hold in place; input keeps being taken until
//   the queue is nearly full, then waits. Nothing is dropped.
`timescale 1ns / 1ps
`default_nettype none

module byte_stream_tokenizer (
  input  wire logic   clk,
  input  wire logic   rst_n,
  bst_in_if.sink      in_stream,
  bst_out_if.source   out_stream
);
  import bst_pkg::*;

  // Scanner state
  mode_t                    mode_r, mode_nxt;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic [START_W-1:0]       pstart_r, pstart_nxt;
  logic [LEN_W-1:0]         plen_r, plen_nxt;
  logic                     kw_r, kw_nxt;

  // Result queue, head at slot 0
  token_t                   q_r [QUEUE_DEPTH];
  token_t                   q_nxt [QUEUE_DEPTH];
  logic [QCNT_W-1:0]        cnt_r, cnt_nxt;

  logic                     in_acc;
  logic                     pop;
  logic [BYTE_W-1:0]        b;
  logic                     eot;
  logic                     b_ws, b_digit, b_word;
  logic                     extend;
  logic                     flush_v;
  logic                     tail_v;
  logic                     begin_int, begin_ident;
  token_t                   flush_tok, tail_tok;
  token_t                   res0, res1;
  logic                     push0, push1;
  logic [QCNT_W-1:0]        cnt_s;

  assign in_acc = in_stream.valid && in_stream.ready;
  assign pop    = out_stream.valid && out_stream.ready;

  // Keep two slots free so any request can be taken without looking at out
  assign in_stream.ready = (cnt_r <= QCNT_W'(QUEUE_DEPTH - 2));

  assign b       = in_stream.text_byte;
  assign eot     = in_stream.end_of_text;
  assign b_ws    = is_ws(b);
  assign b_digit = is_digit(b);
  assign b_word  = is_word_start(b);

  // Byte continues the pending run
  assign extend = !eot &&
                  (((mode_r == MODE_INTEGER) && b_digit) ||
                   ((mode_r == MODE_IDENT) && (b_word || b_digit)));

  // Pending token is closed by whitespace, end, or any non-continuing byte
  assign flush_v     = !extend && (mode_r != MODE_IDLE);
  assign begin_int   = !eot && !extend && b_digit;
  assign begin_ident = !eot && !extend && b_word;
  // End token, or a one-byte illegal token
  assign tail_v      = eot || (!extend && !b_ws && !b_digit && !b_word);

  // Next scanner mode
  always_comb begin
    if (!in_acc) begin
      mode_nxt = mode_r;
    end else if (eot) begin
      mode_nxt = MODE_IDLE;
    end else if (extend) begin
      mode_nxt = mode_r;
    end else if (begin_int) begin
      mode_nxt = MODE_INTEGER;
    end else if (begin_ident) begin
      mode_nxt = MODE_IDENT;
    end else begin
      mode_nxt = MODE_IDLE;
    end
  end

  // Token values and the rest of the scanner state
  always_comb begin
    flush_tok.start  = pstart_r;
    flush_tok.length = plen_r;
    flush_tok.bad    = '0;
    flush_tok.last   = 1'b0;
    if (mode_r == MODE_INTEGER) begin
      flush_tok.kind = KIND_INTEGER;
    end else if (kw_r && (plen_r == KEYWORD_LEN) && (eot || b_ws)) begin
      flush_tok.kind = KIND_PRINT;
    end else begin
      flush_tok.kind = KIND_IDENT;
    end

    tail_tok.start = START_W'(pos_r);
    tail_tok.last  = 1'b1;
    if (eot) begin
      tail_tok.kind   = KIND_END;
      tail_tok.length = '0;
      tail_tok.bad    = '0;
    end else begin
      tail_tok.kind   = KIND_ILLEGAL;
      tail_tok.length = LEN_W'(1);
      tail_tok.bad    = b;
    end

    // Pack into up to two results in emit order
    res0      = flush_v ? flush_tok : tail_tok;
    res0.last = !(flush_v && tail_v);
    res1      = tail_tok;
    push0     = in_acc && (flush_v || tail_v);
    push1     = in_acc && flush_v && tail_v;

    pos_nxt    = pos_r;
    pstart_nxt = pstart_r;
    plen_nxt   = plen_r;
    kw_nxt     = kw_r;
    if (in_acc) begin
      if (eot) begin
        pos_nxt    = '0;
        pstart_nxt = '0;
        plen_nxt   = '0;
        kw_nxt     = 1'b0;
      end else begin
        pos_nxt = pos_r + POSITION_BITS'(1);
        if (extend) begin
          kw_nxt   = kw_r && (plen_r < KEYWORD_LEN) && (b == print_char(plen_r[2:0]));
          plen_nxt = (plen_r == LEN_MAX) ? plen_r : plen_r + LEN_W'(1);
        end else if (begin_int || begin_ident) begin
          pstart_nxt = START_W'(pos_r);
          plen_nxt   = LEN_W'(1);
          kw_nxt     = begin_ident && (b == print_char(3'd0));
        end else begin
          kw_nxt = 1'b0;
        end
      end
    end
  end

  // Queue: advance on pop, append new results behind the survivors
  always_comb begin
    cnt_s = cnt_r - QCNT_W'(pop);
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (pop && (i < QUEUE_DEPTH - 1)) begin
        q_nxt[i] = q_r[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
      end else begin
        q_nxt[i] = q_r[i];
      end
      if (push0 && (cnt_s == QCNT_W'(i))) begin
        q_nxt[i] = res0;
      end
      if (push1 && ((cnt_s + QCNT_W'(1)) == QCNT_W'(i))) begin
        q_nxt[i] = res1;
      end
    end
    cnt_nxt = cnt_s + QCNT_W'(push0) + QCNT_W'(push1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      pos_r    <= '0;
      pstart_r <= '0;
      plen_r   <= '0;
      kw_r     <= 1'b0;
      cnt_r    <= '0;
    end else begin
      mode_r   <= mode_nxt;
      pos_r    <= pos_nxt;
      pstart_r <= pstart_nxt;
      plen_r   <= plen_nxt;
      kw_r     <= kw_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  assign out_stream.valid        = (cnt_r != '0);
  assign out_stream.token_kind   = q_r[0].kind;
  assign out_stream.token_start  = q_r[0].start;
  assign out_stream.token_length = q_r[0].length;
  assign out_stream.illegal_byte = q_r[0].bad;
  assign out_stream.last_of_run  = q_r[0].last;

`ifndef SYNTHESIS
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("result queue count past its depth");

  a_eot_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && eot) |=> (pos_r == '0) && (mode_r == MODE_IDLE))
    else $error("end of text did not restart the scanner");

  a_pending_len: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r != MODE_IDLE) |-> (plen_r != '0))
    else $error("pending token with zero length");

  a_kw_ident: assert property (@(posedge clk) disable iff (!rst_n)
    kw_r |-> (mode_r == MODE_IDENT))
    else $error("keyword match flag outside an identifier");

  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_stream.valid && (q_r[0].kind == KIND_END)) |-> q_r[0].last)
    else $error("end token not marked last");
`endif

endmodule

`default_nettype wire
